/* rtl/tasp_pkg.sv */
// ----------------------------------------------------------------------------
// tasp_pkg
// Shared types and codes of the two-axis step pulse generator.
// ----------------------------------------------------------------------------
package tasp_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_JOG   = 2'd2;
  localparam logic [1:0] CMD_ABORT = 2'd3;

  // Storage widths
  localparam int PERIOD_W = 20;
  localparam int STEPS_W  = 31;
  localparam int SPEED_W  = 32;

  // Shortest legal step period in ticks
  localparam int MIN_PERIOD = 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_TICK,
    S_DONE
  } state_t;

endpackage

/* rtl/two_axis_step_pulse_generator_core.sv */
// ----------------------------------------------------------------------------
// two_axis_step_pulse_generator_core
// Throughput: one transaction at a time; move and jog are set by the shared
// restoring divider, one period bit per cycle; ticks visit one axis a cycle.
// Reset: synchronous active-low rst_n stops both axes and clears the control and
// per-axis state, driver enables included; divider and result registers are not reset.
// ----------------------------------------------------------------------------
module two_axis_step_pulse_generator_core
  import tasp_pkg::*;
#(
  parameter int TICK_RATE = 1000000
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_cmd,
  input  logic                      in_axis,
  input  logic signed [31:0]        in_step_count,
  input  logic                      in_forward,
  input  logic [SPEED_W-1:0]        in_speed_hz,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_step_a,
  output logic                      out_step_b,
  output logic                      out_dir_a,
  output logic                      out_dir_b,
  output logic                      out_enable_a,
  output logic                      out_enable_b,
  output logic                      out_busy_a,
  output logic                      out_busy_b
);

  // Divider widths follow the tick rate
  localparam int DW = $clog2(TICK_RATE + 1);
  localparam int CW = $clog2(DW);

  state_t state_r, state_nxt;
  logic   ax_r, ax_nxt;

  // Per-axis state
  logic [PERIOD_W-1:0] period_r [2];
  logic [PERIOD_W-1:0] period_nxt [2];
  logic [PERIOD_W-1:0] phase_r [2];
  logic [PERIOD_W-1:0] phase_nxt [2];
  logic [STEPS_W-1:0]  steps_r [2];
  logic [STEPS_W-1:0]  steps_nxt [2];
  logic [1:0] jog_r, jog_nxt;
  logic [1:0] run_r, run_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic [1:0] en_r, en_nxt;

  // Divider registers
  logic [DW-1:0]      rem_r, rem_nxt;
  logic [DW-1:0]      quo_r, quo_nxt;
  logic [SPEED_W-1:0] div_r, div_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  // Output register
  logic       out_valid_r;
  logic [7:0] res_r, res_nxt;

  logic accept, out_free;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Divider step: one quotient bit
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            div_ge;
  logic [DW-1:0]   quo_sh;
  logic [DW-1:0]   quo_clamp;
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign div_ge  = SPEED_W'(rem_sh) >= div_r;
  assign rem_sub = rem_sh - div_r[DW:0];
  assign quo_sh  = {quo_r[DW-2:0], div_ge};
  assign quo_clamp = (quo_sh < DW'(MIN_PERIOD)) ? DW'(MIN_PERIOD) : quo_sh;

  // Move magnitude, saturated to 31 bits
  logic [31:0]        mag32;
  logic [STEPS_W-1:0] mag;
  assign mag32 = in_step_count[31] ? (32'd0 - in_step_count) : in_step_count;
  assign mag   = mag32[31] ? {STEPS_W{1'b1}} : mag32[STEPS_W-1:0];

  // Tick unit for the selected axis
  logic [PERIOD_W:0]   ph_inc;
  logic [PERIOD_W-1:0] ph_wrap;
  logic                half_hit;
  logic [STEPS_W-1:0]  steps_dec;
  assign ph_inc    = {1'b0, phase_r[ax_r]} + 1'b1;
  assign ph_wrap   = (ph_inc >= {1'b0, period_r[ax_r]}) ? '0 : ph_inc[PERIOD_W-1:0];
  assign half_hit  = (ph_wrap == (period_r[ax_r] >> 1)) && !jog_r[ax_r];
  assign steps_dec = (steps_r[ax_r] != '0) ? steps_r[ax_r] - 1'b1 : steps_r[ax_r];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_TICK: state_nxt = S_TICK;
            CMD_MOVE: begin
              if (!run_r[in_axis] && (in_step_count != '0)) state_nxt = S_DIV;
              else state_nxt = S_DONE;
            end
            CMD_JOG:   state_nxt = S_DIV;
            CMD_ABORT: state_nxt = S_DONE;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_DIV:  if (cnt_r == '0) state_nxt = S_DONE;
      S_TICK: if (ax_r) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    ax_nxt     = ax_r;
    period_nxt = period_r;
    phase_nxt  = phase_r;
    steps_nxt  = steps_r;
    jog_nxt    = jog_r;
    run_nxt    = run_r;
    dir_nxt    = dir_r;
    en_nxt     = en_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_sh;
    div_nxt    = div_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ax_nxt  = (in_cmd == CMD_TICK) ? 1'b0 : in_axis;
          rem_nxt = '0;
          quo_nxt = DW'(TICK_RATE);
          div_nxt = (in_speed_hz == '0) ? SPEED_W'(1) : in_speed_hz;
          cnt_nxt = CW'(DW - 1);
          unique case (in_cmd)
            CMD_MOVE: begin
              if (!run_r[in_axis] && (in_step_count != '0)) begin
                dir_nxt[in_axis]   = !in_step_count[31];
                steps_nxt[in_axis] = mag;
                jog_nxt[in_axis]   = 1'b0;
                run_nxt[in_axis]   = 1'b1;
                en_nxt[in_axis]    = 1'b1;
                phase_nxt[in_axis] = '0;
              end
            end
            CMD_JOG: begin
              dir_nxt[in_axis]   = in_forward;
              steps_nxt[in_axis] = '0;
              jog_nxt[in_axis]   = 1'b1;
              run_nxt[in_axis]   = 1'b1;
              en_nxt[in_axis]    = 1'b1;
              phase_nxt[in_axis] = '0;
            end
            CMD_ABORT: begin
              steps_nxt[in_axis] = '0;
              jog_nxt[in_axis]   = 1'b0;
              run_nxt[in_axis]   = 1'b0;
              en_nxt[in_axis]    = 1'b0;
              phase_nxt[in_axis] = '0;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        // Advance the restoring divider; store the clamped period at the end
        rem_nxt = div_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) period_nxt[ax_r] = PERIOD_W'(quo_clamp);
      end
      S_TICK: begin
        // Step one axis, then move to the next
        if (run_r[ax_r]) begin
          phase_nxt[ax_r] = ph_wrap;
          if (half_hit) begin
            steps_nxt[ax_r] = steps_dec;
            if (steps_dec == '0) begin
              run_nxt[ax_r]   = 1'b0;
              phase_nxt[ax_r] = '0;
              if (ax_r) en_nxt[ax_r] = 1'b0;
            end
          end
        end
        ax_nxt = 1'b1;
      end
      S_DONE: begin
        // Capture the result once the output register is free
        if (out_free) begin
          res_nxt = {run_r[1], run_r[0], en_r[1], en_r[0], dir_r[1], dir_r[0],
                     run_r[1] && (phase_r[1] < (period_r[1] >> 1)),
                     run_r[0] && (phase_r[0] < (period_r[0] >> 1))};
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= 1'b0;
      period_r    <= '{default: '0};
      phase_r     <= '{default: '0};
      steps_r     <= '{default: '0};
      jog_r       <= '0;
      run_r       <= '0;
      dir_r       <= '0;
      en_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ax_r       <= ax_nxt;
      period_r   <= period_nxt;
      phase_r    <= phase_nxt;
      steps_r    <= steps_nxt;
      jog_r      <= jog_nxt;
      run_r      <= run_nxt;
      dir_r      <= dir_nxt;
      en_r       <= en_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_step_a   = res_r[0];
  assign out_step_b   = res_r[1];
  assign out_dir_a    = res_r[2];
  assign out_dir_b    = res_r[3];
  assign out_enable_a = res_r[4];
  assign out_enable_b = res_r[5];
  assign out_busy_a   = res_r[6];
  assign out_busy_b   = res_r[7];

`ifndef NO_ASSERTIONS
  // A running axis always has its driver enabled
  a_run_en: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r & ~en_r) == 2'b00) else $error("running axis with driver disabled");

  // A jogging axis carries no step budget
  a_jog_steps: assert property (@(posedge clk) disable iff (!rst_n)
    !(jog_r[0] && steps_r[0] != '0) && !(jog_r[1] && steps_r[1] != '0))
    else $error("jog axis with nonzero step count");

  // Accepting a transaction drops ready in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready) else $error("ready held after accept");

  // A result appears only out of the completion state
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");
`endif

endmodule
